// ===== hw/rtl/cbps_pkg.sv =====
// Shared types, constants and helpers for the class-boosted priority scheduler.
package cbps_pkg;

  localparam int NUM_CLASSES = 32;
  localparam int QUEUE_DEPTH = 16;

  localparam int CMD_W  = 2;
  localparam int CLS_W  = $clog2(NUM_CLASSES);
  localparam int TAG_W  = 16;
  localparam int AMT_W  = 21;
  localparam int STAT_W = 2;
  localparam int SLOT_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_W = CLS_W + SLOT_W;
  localparam int WAIT_W = $clog2(NUM_CLASSES + 1);

  localparam int IN_W  = 48;
  localparam int OUT_W = 24;

  typedef enum logic [CMD_W-1:0] {
    CMD_ENQ   = 2'd0,
    CMD_BOOST = 2'd1,
    CMD_SERVE = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE   = 2'd0,
    ST_SERVED = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_ENQ,
    OP_BOOST,
    OP_REMOVE,
    OP_SCAN
  } cell_op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SRCH,
    S_RDTAG,
    S_RDLAST,
    S_SCAN,
    S_RESP
  } state_e;

  typedef struct packed {
    cell_op_e              op;
    logic [CLS_W-1:0]      cls;
    logic signed [31:0]    prio;
    logic [31:0]           arr;
    logic [SLOT_W-1:0]     slot;
    logic signed [AMT_W-1:0] amount;
  } cell_ctl_t;

  typedef struct packed {
    logic                  valid;
    logic signed [32:0]    val;
    logic [31:0]           arr;
    logic [CLS_W-1:0]      cls;
    logic [SLOT_W-1:0]     slot;
  } chain_t;

  typedef struct packed {
    logic signed [31:0]    prio;
    logic [31:0]           arr;
    logic [TAG_W-1:0]      tag;
  } entry_t;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [33:0] hi;
    logic signed [33:0] lo;
    hi = 34'sh0_7FFF_FFFF;
    lo = -34'sh0_8000_0000;
    if (v > hi) begin
      return 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

endpackage

// ===== hw/rtl/class_boosted_priority_scheduler_top.sv =====
// Top level of the class-boosted priority scheduler: control sequencer, entry memory, cell row.
// Enqueue, boost and unused commands go straight from execution to the result beat. Serve
// walks the search chain through one cell per class; if nothing waits it answers empty, else
// it makes two memory reads (winner's tag, class's last entry) and rescans the entries left
// in the served class to rebuild its cached head.
// Throughput: one command at a time; the next beat is taken once the result is registered.
// Reset: asynchronous active low; all queues empty, boosts zero, arrival number one.
module class_boosted_priority_scheduler_top
  import cbps_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata from bit 0: cmd[1:0], class_id[6:2], tag[22:7], amount[43:23], zero fill
  input  logic [IN_W-1:0]  s_axis_tdata,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // tdata from bit 0: status[1:0], served_tag[17:2], served_class[22:18], zero fill
  output logic [OUT_W-1:0] m_axis_tdata
);

  state_e state_q, state_d;

  // Latched command beat.
  cmd_e                    cmd_q;
  logic [CLS_W-1:0]        cls_q;
  logic [TAG_W-1:0]        tag_q;
  logic signed [AMT_W-1:0] amt_q;

  logic [31:0]       arrival_q, arrival_d;
  logic [WAIT_W-1:0] wait_q, wait_d;
  chain_t            best_q, best_d;
  logic [CNT_W-1:0]  scan_idx_q, scan_idx_d;
  logic              pend_q, pend_d;
  logic [SLOT_W-1:0] pend_slot_q, pend_slot_d;

  status_e           res_status_q, res_status_d;
  logic [TAG_W-1:0]  res_tag_q, res_tag_d;
  logic [CLS_W-1:0]  res_cls_q, res_cls_d;

  logic              m_valid_q;
  logic [OUT_W-1:0]  m_data_q;
  logic              out_load;

  // Entry memory, one row per class, one slot per queue place.
  entry_t            mem [2**ADDR_W];
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  entry_t            mem_wdata, mem_rdata_q;

  // Cell row.
  cell_ctl_t          ctl;
  chain_t             chain_w [NUM_CLASSES+1];
  logic [CNT_W-1:0]   counts [NUM_CLASSES];
  logic signed [31:0] boosts [NUM_CLASSES];

  logic               accept;
  logic               cls_ok;
  logic [CNT_W-1:0]   sel_count, best_count;
  logic signed [31:0] sel_boost;
  logic [SLOT_W-1:0]  last_slot;

  assign accept    = s_axis_tvalid && s_axis_tready;
  assign cls_ok    = (32'(cls_q) < 32'(NUM_CLASSES));
  assign sel_count = counts[cls_q];
  assign sel_boost = boosts[cls_q];
  assign best_count = counts[best_q.cls];
  assign last_slot = SLOT_W'(best_count - CNT_W'(1));

  assign chain_w[0] = '0;

  for (genvar g = 0; g < NUM_CLASSES; g++) begin : g_cell
    cbps_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (CLS_W'(g)),
      .ctl_i      (ctl),
      .chain_i    (chain_w[g]),
      .chain_o    (chain_w[g+1]),
      .count_o    (counts[g]),
      .boost_o    (boosts[g])
    );
  end

  always_comb begin
    state_d      = state_q;
    arrival_d    = arrival_q;
    wait_d       = wait_q;
    best_d       = best_q;
    scan_idx_d   = scan_idx_q;
    pend_d       = pend_q;
    pend_slot_d  = pend_slot_q;
    res_status_d = res_status_q;
    res_tag_d    = res_tag_q;
    res_cls_d    = res_cls_q;
    s_axis_tready = (state_q == S_IDLE);
    out_load     = 1'b0;
    ctl          = '0;
    ctl.op       = OP_NONE;
    mem_we       = 1'b0;
    mem_waddr    = '0;
    mem_wdata    = '0;
    mem_raddr    = '0;

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        res_status_d = ST_DONE;
        res_tag_d    = '0;
        res_cls_d    = '0;
        state_d      = S_RESP;
        unique case (cmd_q)
          CMD_ENQ: begin
            if (cls_ok) begin
              if (32'(sel_count) >= 32'(QUEUE_DEPTH)) begin
                res_status_d = ST_FULL;
              end else begin
                ctl.op    = OP_ENQ;
                ctl.cls   = cls_q;
                ctl.prio  = sat32(34'(amt_q) - 34'(sel_boost));
                ctl.arr   = arrival_q;
                ctl.slot  = SLOT_W'(sel_count);
                mem_we    = 1'b1;
                mem_waddr = {cls_q, SLOT_W'(sel_count)};
                mem_wdata.prio = ctl.prio;
                mem_wdata.arr  = arrival_q;
                mem_wdata.tag  = tag_q;
                // Hold the arrival number at its top value.
                if (arrival_q != '1) begin
                  arrival_d = arrival_q + 32'd1;
                end
              end
            end
          end
          CMD_BOOST: begin
            if (cls_ok) begin
              ctl.op     = OP_BOOST;
              ctl.cls    = cls_q;
              ctl.amount = amt_q;
            end
          end
          CMD_SERVE: begin
            wait_d  = '0;
            state_d = S_SRCH;
          end
          default: begin
          end
        endcase
      end
      S_SRCH: begin
        // Let the chain settle through every cell before taking the winner.
        wait_d = wait_q + WAIT_W'(1);
        if (wait_q == WAIT_W'(NUM_CLASSES)) begin
          if (!chain_w[NUM_CLASSES].valid) begin
            res_status_d = ST_EMPTY;
            state_d      = S_RESP;
          end else begin
            best_d    = chain_w[NUM_CLASSES];
            mem_raddr = {chain_w[NUM_CLASSES].cls, chain_w[NUM_CLASSES].slot};
            state_d   = S_RDTAG;
          end
        end
      end
      S_RDTAG: begin
        res_tag_d = mem_rdata_q.tag;
        res_cls_d = best_q.cls;
        mem_raddr = {best_q.cls, last_slot};
        state_d   = S_RDLAST;
      end
      S_RDLAST: begin
        // Move the last entry into the hole and drop the class's cached head.
        mem_we     = 1'b1;
        mem_waddr  = {best_q.cls, best_q.slot};
        mem_wdata  = mem_rdata_q;
        ctl.op     = OP_REMOVE;
        ctl.cls    = best_q.cls;
        scan_idx_d = '0;
        pend_d     = 1'b0;
        state_d    = S_SCAN;
      end
      S_SCAN: begin
        if (pend_q) begin
          ctl.op   = OP_SCAN;
          ctl.cls  = best_q.cls;
          ctl.prio = mem_rdata_q.prio;
          ctl.arr  = mem_rdata_q.arr;
          ctl.slot = pend_slot_q;
        end
        if (scan_idx_q < best_count) begin
          mem_raddr   = {best_q.cls, SLOT_W'(scan_idx_q)};
          pend_d      = 1'b1;
          pend_slot_d = SLOT_W'(scan_idx_q);
          scan_idx_d  = scan_idx_q + CNT_W'(1);
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            res_status_d = ST_SERVED;
            state_d      = S_RESP;
          end
        end
      end
      S_RESP: begin
        if (!m_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      arrival_q   <= 32'd1;
      wait_q      <= '0;
      scan_idx_q  <= '0;
      pend_q      <= 1'b0;
      m_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      arrival_q   <= arrival_d;
      wait_q      <= wait_d;
      scan_idx_q  <= scan_idx_d;
      pend_q      <= pend_d;
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_e'(s_axis_tdata[1:0]);
      cls_q <= s_axis_tdata[6:2];
      tag_q <= s_axis_tdata[22:7];
      amt_q <= s_axis_tdata[43:23];
    end
    best_q       <= best_d;
    pend_slot_q  <= pend_slot_d;
    res_status_q <= res_status_d;
    res_tag_q    <= res_tag_d;
    res_cls_q    <= res_cls_d;
    if (out_load) begin
      m_data_q <= {1'b0, res_cls_q, res_tag_q, res_status_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_q <= mem[mem_raddr];
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

// ===== hw/rtl/cbps_cell.sv =====
// One class cell: count, boost, cached best entry and one stage of the search chain.
module cbps_cell
  import cbps_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [CLS_W-1:0]         cell_idx_i,
  input  cell_ctl_t                ctl_i,
  input  chain_t                   chain_i,
  output chain_t                   chain_o,
  output logic [CNT_W-1:0]         count_o,
  output logic signed [31:0]       boost_o
);

  logic [CNT_W-1:0]   count_q, count_d;
  logic signed [31:0] boost_q, boost_d;
  logic               bvld_q, bvld_d;
  logic signed [31:0] bprio_q, bprio_d;
  logic [31:0]        barr_q, barr_d;
  logic [SLOT_W-1:0]  bslot_q, bslot_d;
  chain_t             chain_q, chain_d;
  chain_t             mine;
  logic               hit, cand_better, take_mine;

  assign hit = (ctl_i.cls == cell_idx_i);
  // Within a class the boost is common, so compare stored priorities directly.
  assign cand_better = !bvld_q || (ctl_i.prio > bprio_q) ||
                       ((ctl_i.prio == bprio_q) && (ctl_i.arr < barr_q));

  always_comb begin
    count_d = count_q;
    boost_d = boost_q;
    bvld_d  = bvld_q;
    bprio_d = bprio_q;
    barr_d  = barr_q;
    bslot_d = bslot_q;
    unique case (ctl_i.op)
      OP_ENQ: begin
        if (hit) begin
          count_d = count_q + CNT_W'(1);
          if (cand_better) begin
            bvld_d  = 1'b1;
            bprio_d = ctl_i.prio;
            barr_d  = ctl_i.arr;
            bslot_d = ctl_i.slot;
          end
        end
      end
      OP_SCAN: begin
        if (hit && cand_better) begin
          bvld_d  = 1'b1;
          bprio_d = ctl_i.prio;
          barr_d  = ctl_i.arr;
          bslot_d = ctl_i.slot;
        end
      end
      OP_BOOST: begin
        if (hit) begin
          boost_d = sat32(34'(boost_q) + 34'(ctl_i.amount));
        end
      end
      OP_REMOVE: begin
        if (hit) begin
          count_d = count_q - CNT_W'(1);
          bvld_d  = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // Pass the better of the incoming candidate and this class's head down the chain.
  always_comb begin
    mine.valid = bvld_q;
    mine.val   = 33'(bprio_q) + 33'(boost_q);
    mine.arr   = barr_q;
    mine.cls   = cell_idx_i;
    mine.slot  = bslot_q;
    take_mine  = bvld_q && (!chain_i.valid || (mine.val > chain_i.val) ||
                 ((mine.val == chain_i.val) && (mine.arr < chain_i.arr)));
    chain_d    = take_mine ? mine : chain_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      boost_q <= '0;
      bvld_q  <= 1'b0;
      bprio_q <= '0;
      barr_q  <= '0;
      bslot_q <= '0;
      chain_q <= '0;
    end else begin
      count_q <= count_d;
      boost_q <= boost_d;
      bvld_q  <= bvld_d;
      bprio_q <= bprio_d;
      barr_q  <= barr_d;
      bslot_q <= bslot_d;
      chain_q <= chain_d;
    end
  end

  assign chain_o = chain_q;
  assign count_o = count_q;
  assign boost_o = boost_q;

endmodule

// ===== hw/rtl/cbps_checker.sv =====
// Port-level assertions for the scheduler, bound to the top level.
module cbps_checker
  import cbps_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic [IN_W-1:0]  s_axis_tdata,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata
);

  // Hold the result beat while it is stalled.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // Only a served result carries a tag and class.
  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[1:0] != ST_SERVED) |-> (m_axis_tdata[22:2] == '0))
    else $error("tag or class set on a non-served result");

  // One command at a time: input closes right after an accepted beat.
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready while a command is in progress");

  // A result beat never appears in the cycle right after an accept.
  a_min_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("result appeared too early");

endmodule

bind class_boosted_priority_scheduler_top cbps_checker u_cbps_checker (.*);

// ===== tb/tb_top.sv =====
// Self-checking testbench for the class-boosted priority scheduler.
`timescale 1ns / 100ps

module tb_top;
  import cbps_pkg::*;

  localparam int IDLE_LIMIT = 4000;

  logic             clk_i;
  logic             rst_ni;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata;
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [OUT_W-1:0] m_axis_tdata;

  class_boosted_priority_scheduler_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // Packed from the top bit down, so status lands in the lowest bits.
  typedef struct packed {
    logic [CLS_W-1:0]  cls;
    logic [TAG_W-1:0]  tag;
    logic [STAT_W-1:0] status;
  } grant_t;

  // Shadow scheduler state.
  logic signed [31:0] sh_prio  [NUM_CLASSES][QUEUE_DEPTH];
  logic [31:0]        sh_arr   [NUM_CLASSES][QUEUE_DEPTH];
  logic [TAG_W-1:0]   sh_tag   [NUM_CLASSES][QUEUE_DEPTH];
  int                 sh_count [NUM_CLASSES];
  logic signed [31:0] sh_boost [NUM_CLASSES];
  logic [31:0]        sh_next_arr;

  logic [IN_W-1:0] cmd_q[$];
  grant_t          grant_q[$];
  int              errors;
  int              n_sent;
  int              n_served;
  int              n_full;
  int              n_empty;
  int              idle_cycles;

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic grant_t schedule(input logic [IN_W-1:0] beat);
    cmd_e   cmd;
    int     c;
    longint amt;
    longint v;
    longint bval;
    logic [31:0] barr;
    int     bc;
    int     bs;
    int     last;
    bit     found;
    grant_t g;
    cmd = cmd_e'(beat[1:0]);
    c   = int'(beat[6:2]);
    amt = longint'($signed(beat[43:23]));
    g   = '0;
    g.status = ST_DONE;
    found = 0;
    bval = 0;
    barr = 0;
    bc = 0;
    bs = 0;
    case (cmd)
      CMD_ENQ: begin
        if (sh_count[c] >= QUEUE_DEPTH) begin
          g.status = ST_FULL;
        end else begin
          sh_prio[c][sh_count[c]] = clamp32(amt - longint'(sh_boost[c]));
          sh_arr[c][sh_count[c]]  = sh_next_arr;
          sh_tag[c][sh_count[c]]  = beat[22:7];
          sh_count[c]++;
          if (sh_next_arr != 32'hFFFF_FFFF) sh_next_arr++;
        end
      end
      CMD_BOOST: sh_boost[c] = clamp32(longint'(sh_boost[c]) + amt);
      CMD_SERVE: begin
        for (int k = 0; k < NUM_CLASSES; k++) begin
          for (int s = 0; s < sh_count[k]; s++) begin
            v = longint'(sh_prio[k][s]) + longint'(sh_boost[k]);
            if (!found || v > bval || (v == bval && sh_arr[k][s] < barr)) begin
              found = 1;
              bval = v;
              barr = sh_arr[k][s];
              bc = k;
              bs = s;
            end
          end
        end
        if (!found) begin
          g.status = ST_EMPTY;
        end else begin
          last = sh_count[bc] - 1;
          g.status = ST_SERVED;
          g.tag = sh_tag[bc][bs];
          g.cls = CLS_W'(bc);
          sh_prio[bc][bs] = sh_prio[bc][last];
          sh_arr[bc][bs]  = sh_arr[bc][last];
          sh_tag[bc][bs]  = sh_tag[bc][last];
          sh_count[bc] = last;
        end
      end
      default: ;
    endcase
    return g;
  endfunction

  function automatic logic [IN_W-1:0] pack_cmd(cmd_e cmd, int c, int tag, int amt);
    logic [IN_W-1:0] b;
    logic [AMT_W-1:0] a;
    a = AMT_W'(amt);
    b = '0;
    b[1:0]   = cmd;
    b[6:2]   = CLS_W'(c);
    b[22:7]  = TAG_W'(tag);
    b[43:23] = a;
    return b;
  endfunction

  // Append one command beat to the pending queue.
  function automatic void add_cmd(input logic [IN_W-1:0] b);
    cmd_q = {cmd_q, b};
  endfunction

  // Random priority: mostly small so ties and boosts matter, sometimes extreme.
  function automatic int rand_amount();
    case ($urandom_range(0, 9))
      0: return -1048576;
      1: return 1048575;
      2, 3: return int'($urandom_range(0, 2097151)) - 1048576;
      default: return int'($urandom_range(0, 8)) - 4;
    endcase
  endfunction

  initial begin
    int hot;
    for (int k = 0; k < NUM_CLASSES; k++) begin
      sh_count[k] = 0;
      sh_boost[k] = '0;
    end
    sh_next_arr = 32'd1;

    // Directed: empty serve, extremes, ties, large boosts, full class, unused command.
    add_cmd(pack_cmd(CMD_SERVE, 0, 0, 0));
    add_cmd(pack_cmd(CMD_ENQ, 0, 16'hFFFF, 1048575));
    add_cmd(pack_cmd(CMD_ENQ, 31, 16'h0000, -1048576));
    add_cmd(pack_cmd(CMD_ENQ, 5, 16'h1234, 1048575));
    add_cmd(pack_cmd(CMD_SERVE, 0, 0, 0));
    add_cmd(pack_cmd(CMD_SERVE, 0, 0, 0));
    for (int i = 0; i < 20; i++)
      add_cmd(pack_cmd(CMD_BOOST, 31, 0, 1048575));
    for (int i = 0; i < 3; i++)
      add_cmd(pack_cmd(CMD_BOOST, 31, 0, -1048576));
    add_cmd(pack_cmd(CMD_ENQ, 31, 16'hAAAA, -1048576));
    for (int i = 0; i < QUEUE_DEPTH + 1; i++)
      add_cmd(pack_cmd(CMD_ENQ, 7, 16'h5500 + i, 0));
    add_cmd(pack_cmd(CMD_NOP, 31, 16'hFFFF, -1));
    for (int i = 0; i < QUEUE_DEPTH + 4; i++)
      add_cmd(pack_cmd(CMD_SERVE, 0, 0, 0));

    // Random: a few hot classes most of the time so queues fill up.
    for (int i = 0; i < 740; i++) begin
      hot = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 3);
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7, 8:
          add_cmd(pack_cmd(CMD_ENQ, hot, $urandom_range(0, 65535), rand_amount()));
        9, 10, 11:
          add_cmd(pack_cmd(CMD_BOOST, hot, $urandom_range(0, 65535), rand_amount()));
        12:
          add_cmd(pack_cmd(CMD_NOP, hot, $urandom_range(0, 65535), rand_amount()));
        default:
          add_cmd(pack_cmd(CMD_SERVE, hot, $urandom_range(0, 65535), rand_amount()));
      endcase
    end
  end

  // Driver: hold each beat until accepted, then draw a random idle gap before the next beat.
  int gap;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      gap           <= 0;
    end else if (s_axis_tvalid && !s_axis_tready) begin
      // hold
    end else begin
      if (s_axis_tvalid) begin
        grant_q = {grant_q, schedule(s_axis_tdata)};
        n_sent <= n_sent + 1;
      end
      if (gap > 0 || cmd_q.size() == 0) begin
        s_axis_tvalid <= 1'b0;
        if (gap > 0) gap <= gap - 1;
      end else begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= cmd_q.pop_front();
        gap           <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3);
      end
    end
  end

  // Monitor: check each result beat against the oldest expectation; stall at random.
  int stall;
  always @(posedge clk_i or negedge rst_ni) begin
    grant_t exp_g;
    grant_t got;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall         <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[22:0];
        if (grant_q.size() == 0) begin
          $display("%0t: unexpected result beat %h", $time, got);
          errors++;
        end else begin
          exp_g = grant_q.pop_front();
          if (got.status == ST_SERVED) n_served++;
          if (got.status == ST_FULL) n_full++;
          if (got.status == ST_EMPTY) n_empty++;
          if (got.status !== exp_g.status) begin
            $display("%0t: status expected %0d actual %0d", $time, exp_g.status, got.status);
            errors++;
          end
          if (got.tag !== exp_g.tag) begin
            $display("%0t: served_tag expected %h actual %h", $time, exp_g.tag, got.tag);
            errors++;
          end
          if (got.cls !== exp_g.cls) begin
            $display("%0t: served_class expected %0d actual %0d", $time, exp_g.cls, got.cls);
            errors++;
          end
        end
        stall <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3);
        m_axis_tready <= 1'b0;
      end else if (stall > 0) begin
        stall <= stall - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog: count cycles with no beat on either side.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: watchdog expired", $time);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    errors = 0;
    n_sent = 0;
    n_served = 0;
    n_full = 0;
    n_empty = 0;
    idle_cycles = 0;
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    wait (cmd_q.size() == 0 && !s_axis_tvalid);
    wait (grant_q.size() == 0);
    repeat (100) @(posedge clk_i);
    $display("Commands sent: %0d; served %0d, empty %0d, full refusals %0d",
             n_sent, n_served, n_empty, n_full);
    if (errors == 0 && grant_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== class_boosted_priority_scheduler_top.f =====
hw/rtl/cbps_pkg.sv
hw/rtl/cbps_cell.sv
hw/rtl/class_boosted_priority_scheduler_top.sv
hw/rtl/cbps_checker.sv
tb/tb_top.sv
